@@ src/ofrp_pkg.sv @@
// Shared types, codes and helpers of the object file record parser.
// No dependencies; the parser, the result queue and the top level import this package.
package ofrp_pkg;

    localparam int LABEL_CHARS_DEF = 32;
    localparam int RES_QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        KIND_RELOC     = 4'd0,
        KIND_IMPORT    = 4'd1,
        KIND_EXPORT    = 4'd2,
        KIND_BSS       = 4'd3,
        KIND_LABEL     = 4'd4,
        KIND_SEG_HEAD  = 4'd5,
        KIND_SEG_BYTE  = 4'd6,
        KIND_DONE      = 4'd7,
        KIND_ERROR     = 4'd8
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_MAGIC       = 3'd1,
        ERR_RELOC_LEN   = 3'd2,
        ERR_BSS_LEN     = 3'd3,
        ERR_HDR_OVERRUN = 3'd4,
        ERR_SEG_TYPE    = 3'd5,
        ERR_SEG_OVERRUN = 3'd6,
        ERR_SHORT_REC   = 3'd7
    } t_err;

    // header record types
    localparam logic [7:0] REC_RELOC  = 8'd1;
    localparam logic [7:0] REC_IMPORT = 8'd2;
    localparam logic [7:0] REC_EXPORT = 8'd3;
    localparam logic [7:0] REC_BSS    = 8'd5;

    // fixed record lengths and minimum lengths
    localparam logic [7:0] RELOC_LEN  = 8'd8;
    localparam logic [7:0] BSS_LEN    = 8'd4;
    localparam logic [7:0] IMPORT_MIN = 8'd3;
    localparam logic [7:0] EXPORT_MIN = 8'd6;

    // segment types
    localparam logic [7:0] SEG_CODE = 8'd1;
    localparam logic [7:0] SEG_DATA = 8'd2;

    // file layout
    localparam logic [31:0] MAGIC_LAST    = 32'd5;
    localparam logic [31:0] SIZES_LAST    = 32'd13;
    localparam logic [31:0] DATA_BASE     = 32'd10;
    localparam logic [31:0] HDR_BASE      = 32'd14;
    localparam logic [3:0]  STEP_MAX      = 4'd15;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] segment;
        logic [31:0] offset;
        logic [31:0] size;
        logic [15:0] ref_segment;
        logic [7:0]  flags;
        logic [1:0]  segment_type;
        logic [7:0]  data_byte;
        t_err        error_code;
    } t_result;

    // results of one parsed item: a record-like result, then done or error
    typedef struct packed {
        logic    prim_valid;
        t_result prim;
        logic    fin_valid;
        t_result fin;
    } t_emit;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h52;
            3'd1:    v = 8'h44;
            3'd2:    v = 8'h4F;
            3'd3:    v = 8'h46;
            3'd4:    v = 8'h46;
            3'd5:    v = 8'h32;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ src/ofrp_if.sv @@
// Valid/ready channel interfaces of the object file record parser.
// No dependencies: one interface for file bytes, one for parsed results.
interface ofrp_item_if;
    logic       valid;
    logic       ready;
    logic       start_of_file;
    logic [7:0] in_byte;

    modport source(output valid, output start_of_file, output in_byte, input ready);
    modport sink(input valid, input start_of_file, input in_byte, output ready);
endinterface

interface ofrp_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [15:0] segment;
    logic [31:0] offset;
    logic [31:0] size;
    logic [15:0] ref_segment;
    logic [7:0]  flags;
    logic [1:0]  segment_type;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;

    modport source(output valid, output kind, output segment, output offset, output size,
                   output ref_segment, output flags, output segment_type, output data_byte,
                   output error_code, input ready);
    modport sink(input valid, input kind, input segment, input offset, input size,
                 input ref_segment, input flags, input segment_type, input data_byte,
                 input error_code, output ready);
endinterface

@@ src/ofrp_parser.sv @@
// Input register, parse state and per-byte decode of the record parser.
// Depends on ofrp_pkg; hands up to two results per byte to the result queue.
module ofrp_parser #(
    parameter int LABEL_CHARS = ofrp_pkg::LABEL_CHARS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_start_of_file,
    input  logic [7:0]       i_in_byte,
    output logic             o_in_ready,
    input  logic             i_room,
    output ofrp_pkg::t_emit  o_emit
);
    import ofrp_pkg::*;

    localparam int LCW = $clog2(LABEL_CHARS);
    localparam logic [LCW-1:0] LABEL_MAX = LCW'(LABEL_CHARS - 1);

    typedef enum logic [2:0] {
        PH_MAGIC, PH_SIZES, PH_RTYPE, PH_RLEN, PH_RBODY, PH_SHEAD, PH_SDATA, PH_IDLE
    } t_phase;

    // input register
    logic        r_in_valid;
    logic        r_start;
    logic [7:0]  r_byte;

    // parse state
    t_phase           r_phase,        n_phase,        c_phase;
    logic [31:0]      r_pos,          n_pos,          c_pos;
    logic [31:0]      r_data_end,     n_data_end,     c_data_end;
    logic [31:0]      r_header_end,   n_header_end,   c_header_end;
    logic [7:0]       r_rec_kind,     n_rec_kind,     c_rec_kind;
    logic [7:0]       r_rec_left,     n_rec_left,     c_rec_left;
    logic [31:0]      r_field_shift,  n_field_shift,  c_field_shift;
    logic [3:0]       r_field_step,   n_field_step,   c_field_step;
    logic [LCW-1:0]   r_label_count,  n_label_count,  c_label_count;
    logic             r_label_ended,  n_label_ended,  c_label_ended;
    logic [31:0]      r_bss_total,    n_bss_total,    c_bss_total;
    logic [15:0]      r_held_segment, n_held_segment, c_held_segment;
    logic [31:0]      r_held_offset,  n_held_offset,  c_held_offset;
    logic [7:0]       r_held_small,   n_held_small,   c_held_small;
    logic [31:0]      r_seg_left,     n_seg_left,     c_seg_left;

    logic        accept;
    logic        fire;
    logic [31:0] np;
    logic [31:0] b32;
    logic [3:0]  st;
    logic [3:0]  st_m1;
    logic [3:0]  st_m2;
    logic [3:0]  st_m6;
    logic [3:0]  pos_m6;
    logic [3:0]  pos_m10;
    logic        do_hdr_bnd;
    logic        do_seg_bnd;
    logic        do_label;
    logic        e_fail;
    t_err        e_code;
    logic        prim_v;
    t_result     prim;
    logic        fin_v;
    t_result     fin;

    assign fire       = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || i_room;
    assign accept     = i_in_valid && o_in_ready;

    // a start flag clears everything before this byte is parsed
    always_comb begin
        c_phase        = r_start ? PH_MAGIC : r_phase;
        c_pos          = r_start ? '0 : r_pos;
        c_data_end     = r_start ? '0 : r_data_end;
        c_header_end   = r_start ? '0 : r_header_end;
        c_rec_kind     = r_start ? '0 : r_rec_kind;
        c_rec_left     = r_start ? '0 : r_rec_left;
        c_field_shift  = r_start ? '0 : r_field_shift;
        c_field_step   = r_start ? '0 : r_field_step;
        c_label_count  = r_start ? '0 : r_label_count;
        c_label_ended  = r_start ? 1'b0 : r_label_ended;
        c_bss_total    = r_start ? '0 : r_bss_total;
        c_held_segment = r_start ? '0 : r_held_segment;
        c_held_offset  = r_start ? '0 : r_held_offset;
        c_held_small   = r_start ? '0 : r_held_small;
        c_seg_left     = r_start ? '0 : r_seg_left;
    end

    assign np      = (c_pos == 32'hFFFF_FFFF) ? c_pos : c_pos + 32'd1;
    assign b32     = {24'd0, r_byte};
    assign st      = c_field_step;
    assign st_m1   = st - 4'd1;
    assign st_m2   = st - 4'd2;
    assign st_m6   = st - 4'd6;
    assign pos_m6  = c_pos[3:0] - 4'd6;
    assign pos_m10 = c_pos[3:0] - 4'd10;

    always_comb begin
        n_phase        = c_phase;
        n_pos          = c_pos;
        n_data_end     = c_data_end;
        n_header_end   = c_header_end;
        n_rec_kind     = c_rec_kind;
        n_rec_left     = c_rec_left;
        n_field_shift  = c_field_shift;
        n_field_step   = c_field_step;
        n_label_count  = c_label_count;
        n_label_ended  = c_label_ended;
        n_bss_total    = c_bss_total;
        n_held_segment = c_held_segment;
        n_held_offset  = c_held_offset;
        n_held_small   = c_held_small;
        n_seg_left     = c_seg_left;
        do_hdr_bnd     = 1'b0;
        do_seg_bnd     = 1'b0;
        do_label       = 1'b0;
        e_fail         = 1'b0;
        e_code         = ERR_NONE;
        prim_v         = 1'b0;
        prim           = '0;
        fin_v          = 1'b0;
        fin            = '0;

        if (c_phase != PH_IDLE) begin
            n_pos = np;
        end

        case (c_phase)
            PH_MAGIC: begin
                if (c_pos > MAGIC_LAST || r_byte != magic_byte(c_pos[2:0])) begin
                    e_fail = 1'b1;
                    e_code = ERR_MAGIC;
                end else if (c_pos == MAGIC_LAST) begin
                    n_phase = PH_SIZES;
                end
            end
            PH_SIZES: begin
                if (c_pos >= 32'd6 && c_pos <= 32'd9) begin
                    n_data_end = c_data_end | (b32 << {pos_m6[1:0], 3'b000});
                end else if (c_pos >= 32'd10 && c_pos <= SIZES_LAST) begin
                    n_header_end = c_header_end | (b32 << {pos_m10[1:0], 3'b000});
                end
                if (c_pos >= SIZES_LAST) begin
                    n_data_end   = sat_add(n_data_end, DATA_BASE);
                    n_header_end = sat_add(n_header_end, HDR_BASE);
                    do_hdr_bnd   = 1'b1;
                end
            end
            PH_RTYPE: begin
                n_rec_kind = r_byte;
                n_phase    = PH_RLEN;
            end
            PH_RLEN: begin
                n_field_step   = '0;
                n_field_shift  = '0;
                n_held_segment = '0;
                n_held_offset  = '0;
                n_held_small   = '0;
                n_label_count  = '0;
                n_label_ended  = 1'b0;
                n_rec_left     = r_byte;
                if (c_rec_kind == REC_RELOC && r_byte != RELOC_LEN) begin
                    e_fail = 1'b1;
                    e_code = ERR_RELOC_LEN;
                end else if (c_rec_kind == REC_BSS && r_byte != BSS_LEN) begin
                    e_fail = 1'b1;
                    e_code = ERR_BSS_LEN;
                end else if ((c_rec_kind == REC_IMPORT && r_byte < IMPORT_MIN) ||
                             (c_rec_kind == REC_EXPORT && r_byte < EXPORT_MIN)) begin
                    e_fail = 1'b1;
                    e_code = ERR_SHORT_REC;
                end else if (r_byte == 8'd0) begin
                    do_hdr_bnd = 1'b1;
                end else begin
                    n_phase = PH_RBODY;
                end
            end
            PH_RBODY: begin
                if (st < STEP_MAX) begin
                    n_field_step = st + 4'd1;
                end
                n_rec_left = c_rec_left - 8'd1;
                case (c_rec_kind)
                    REC_RELOC: begin
                        if (st == 4'd0) begin
                            n_held_segment = {8'd0, r_byte};
                        end else if (st <= 4'd4) begin
                            n_held_offset = c_held_offset | (b32 << {st_m1[1:0], 3'b000});
                        end else if (st == 4'd5) begin
                            n_held_small = r_byte;
                        end else if (st == 4'd6) begin
                            n_field_shift = b32;
                        end else if (st == 4'd7) begin
                            n_field_shift     = c_field_shift | (b32 << 8);
                            prim_v            = 1'b1;
                            prim.kind         = KIND_RELOC;
                            prim.segment      = c_held_segment;
                            prim.offset       = c_held_offset;
                            prim.size         = {24'd0, c_held_small};
                            prim.ref_segment  = n_field_shift[15:0];
                        end
                    end
                    REC_IMPORT: begin
                        if (st == 4'd1) begin
                            n_held_segment = {8'd0, r_byte};
                        end else if (st == 4'd2) begin
                            n_held_segment = c_held_segment | {r_byte, 8'd0};
                            prim_v         = 1'b1;
                            prim.kind      = KIND_IMPORT;
                            prim.segment   = n_held_segment;
                        end else if (st >= 4'd3) begin
                            do_label = 1'b1;
                        end
                    end
                    REC_EXPORT: begin
                        if (st == 4'd0) begin
                            n_held_small = r_byte;
                        end else if (st == 4'd1) begin
                            n_held_segment = {8'd0, r_byte};
                        end else if (st <= 4'd5) begin
                            n_held_offset = c_held_offset | (b32 << {st_m2[1:0], 3'b000});
                            if (st == 4'd5) begin
                                prim_v       = 1'b1;
                                prim.kind    = KIND_EXPORT;
                                prim.segment = c_held_segment;
                                prim.offset  = n_held_offset;
                                prim.flags   = c_held_small;
                            end
                        end else begin
                            do_label = 1'b1;
                        end
                    end
                    REC_BSS: begin
                        if (st <= 4'd3) begin
                            n_field_shift = c_field_shift | (b32 << {st[1:0], 3'b000});
                            if (st == 4'd3) begin
                                n_bss_total = c_bss_total + n_field_shift;
                                prim_v      = 1'b1;
                                prim.kind   = KIND_BSS;
                                prim.size   = n_field_shift;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                // label chars: stop at a zero byte or when the label is full
                if (do_label && !c_label_ended && c_label_count < LABEL_MAX) begin
                    if (r_byte == 8'd0) begin
                        n_label_ended = 1'b1;
                    end else begin
                        prim_v         = 1'b1;
                        prim.kind      = KIND_LABEL;
                        prim.segment   = c_held_segment;
                        prim.data_byte = r_byte;
                        n_label_count  = c_label_count + 1'b1;
                    end
                end
                if (n_rec_left == 8'd0) begin
                    do_hdr_bnd = 1'b1;
                end
            end
            PH_SHEAD: begin
                if (st < STEP_MAX) begin
                    n_field_step = st + 4'd1;
                end
                if (st == 4'd0) begin
                    n_held_small = r_byte;
                end else if (st == 4'd1) begin
                    if (r_byte != 8'd0) begin
                        n_held_small = '0;
                    end
                end else if (st == 4'd2) begin
                    n_held_segment = {8'd0, r_byte};
                end else if (st == 4'd3) begin
                    n_held_segment = c_held_segment | {r_byte, 8'd0};
                end else if (st >= 4'd6 && st <= 4'd9) begin
                    n_seg_left = c_seg_left | (b32 << {st_m6[1:0], 3'b000});
                    if (st == 4'd9) begin
                        if (n_seg_left == 32'd0) begin
                            do_seg_bnd = 1'b1;
                        end else if (c_held_small != SEG_CODE && c_held_small != SEG_DATA) begin
                            e_fail = 1'b1;
                            e_code = ERR_SEG_TYPE;
                        end else begin
                            prim_v            = 1'b1;
                            prim.kind         = KIND_SEG_HEAD;
                            prim.segment      = c_held_segment;
                            prim.size         = n_seg_left;
                            prim.segment_type = c_held_small[1:0];
                            n_held_offset     = '0;
                            n_phase           = PH_SDATA;
                        end
                    end
                end
            end
            PH_SDATA: begin
                prim_v         = 1'b1;
                prim.kind      = KIND_SEG_BYTE;
                prim.segment   = c_held_segment;
                prim.offset    = c_held_offset;
                prim.data_byte = r_byte;
                n_held_offset  = c_held_offset + 32'd1;
                n_seg_left     = c_seg_left - 32'd1;
                if (n_seg_left == 32'd0) begin
                    do_seg_bnd = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // header end: reached exactly starts the segments, past it is an overrun
        if (do_hdr_bnd) begin
            if (np == n_header_end) begin
                do_seg_bnd = 1'b1;
            end else if (np > n_header_end) begin
                e_fail = 1'b1;
                e_code = ERR_HDR_OVERRUN;
            end else begin
                n_phase = PH_RTYPE;
            end
        end

        // data end: reached exactly finishes the file, past it is an overrun
        if (do_seg_bnd) begin
            if (np == n_data_end) begin
                fin_v    = 1'b1;
                fin.kind = KIND_DONE;
                fin.size = n_bss_total;
                n_phase  = PH_IDLE;
            end else if (np > n_data_end) begin
                e_fail = 1'b1;
                e_code = ERR_SEG_OVERRUN;
            end else begin
                n_phase        = PH_SHEAD;
                n_field_step   = '0;
                n_held_small   = '0;
                n_held_segment = '0;
                n_seg_left     = '0;
            end
        end

        if (e_fail) begin
            fin_v          = 1'b1;
            fin            = '0;
            fin.kind       = KIND_ERROR;
            fin.error_code = e_code;
            n_phase        = PH_IDLE;
        end
    end

    always_comb begin
        o_emit.prim_valid = fire && prim_v;
        o_emit.prim       = prim;
        o_emit.fin_valid  = fire && fin_v;
        o_emit.fin        = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_start        <= 1'b0;
            r_byte         <= '0;
            r_phase        <= PH_MAGIC;
            r_pos          <= '0;
            r_data_end     <= '0;
            r_header_end   <= '0;
            r_rec_kind     <= '0;
            r_rec_left     <= '0;
            r_field_shift  <= '0;
            r_field_step   <= '0;
            r_label_count  <= '0;
            r_label_ended  <= 1'b0;
            r_bss_total    <= '0;
            r_held_segment <= '0;
            r_held_offset  <= '0;
            r_held_small   <= '0;
            r_seg_left     <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
                r_start    <= i_start_of_file;
                r_byte     <= i_in_byte;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_phase        <= n_phase;
                r_pos          <= n_pos;
                r_data_end     <= n_data_end;
                r_header_end   <= n_header_end;
                r_rec_kind     <= n_rec_kind;
                r_rec_left     <= n_rec_left;
                r_field_shift  <= n_field_shift;
                r_field_step   <= n_field_step;
                r_label_count  <= n_label_count;
                r_label_ended  <= n_label_ended;
                r_bss_total    <= n_bss_total;
                r_held_segment <= n_held_segment;
                r_held_offset  <= n_held_offset;
                r_held_small   <= n_held_small;
                r_seg_left     <= n_seg_left;
            end
        end
    end

endmodule

@@ src/ofrp_out_fifo.sv @@
// Record parser result queue: takes up to two results a cycle, gives one on ready.
// Depends on ofrp_pkg for the result types and the queue depth.
module ofrp_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ofrp_pkg::t_emit   i_emit,
    output logic              o_room,
    output logic              o_valid,
    output ofrp_pkg::t_result o_data,
    input  logic              i_ready
);
    import ofrp_pkg::*;

    localparam int PW = $clog2(RES_QUEUE_DEPTH);
    localparam int CW = $clog2(RES_QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(RES_QUEUE_DEPTH - 2);

    t_result         r_mem [RES_QUEUE_DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   fin_addr;
    logic            pop;

    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rptr];
    assign o_room   = (r_count <= ROOM_LIMIT);
    assign pop      = o_valid && i_ready;
    assign fin_addr = r_wptr + PW'(i_emit.prim_valid);

    always_comb begin
        n_wptr  = r_wptr + PW'(i_emit.prim_valid) + PW'(i_emit.fin_valid);
        n_count = r_count + CW'(i_emit.prim_valid) + CW'(i_emit.fin_valid) - CW'(pop);
    end

    // payload entries hold without reset
    always_ff @(posedge i_clk) begin
        if (i_emit.prim_valid) begin
            r_mem[r_wptr] <= i_emit.prim;
        end
        if (i_emit.fin_valid) begin
            r_mem[fin_addr] <= i_emit.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_count <= n_count;
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

endmodule

@@ src/object_file_record_parser_top.sv @@
// Object file record parser: streaming parse of an object file, one byte per item.
// Depends on ofrp_pkg, ofrp_if, ofrp_parser and ofrp_out_fifo.
//
// Usage:
//  - i_item carries one file byte per item; start_of_file marks byte 0 of a
//    new file and restarts the parse. Bytes without a start flag after reset
//    are parsed as a file that begins at byte 0.
//  - o_result carries parsed results: relocation, import, export and BSS
//    records, label chars, segment headers, segment data bytes, a done
//    result with the BSS total, or a numbered error. After done or an error
//    bytes give nothing until the next start flag.
//  - Path: an accepted byte is held in the input register, then parsed from it
//    into the result queue, from which its results are offered.
//  - Throughput: one byte per cycle while bytes give at most one result and the
//    receiver takes them; a byte that gives two results (a record followed by done
//    or an error) takes longer to drain through the single-ported result output.
//  - Stall: the result queue holds four results; when fewer than two slots
//    are free, the parser holds its input register and i_item.ready drops
//    once that register is full. Nothing is dropped.
//  - Reset (synchronous, active low) empties the queue and input register
//    and returns the parser to the magic check.
module object_file_record_parser_top #(
    parameter int LABEL_CHARS = ofrp_pkg::LABEL_CHARS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ofrp_item_if.sink     i_item,
    ofrp_result_if.source o_result
);
    import ofrp_pkg::*;

    t_emit   emit;
    logic    room;
    t_result head;

    // input register, parse state and decode
    ofrp_parser #(
        .LABEL_CHARS(LABEL_CHARS)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_item.valid),
        .i_start_of_file (i_item.start_of_file),
        .i_in_byte       (i_item.in_byte),
        .o_in_ready      (i_item.ready),
        .i_room          (room),
        .o_emit          (emit)
    );

    // result queue decouples a stalled receiver from the byte stream
    ofrp_out_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room  (room),
        .o_valid (o_result.valid),
        .o_data  (head),
        .i_ready (o_result.ready)
    );

    // unpack the head result onto the channel
    assign o_result.kind         = head.kind;
    assign o_result.segment      = head.segment;
    assign o_result.offset       = head.offset;
    assign o_result.size         = head.size;
    assign o_result.ref_segment  = head.ref_segment;
    assign o_result.flags        = head.flags;
    assign o_result.segment_type = head.segment_type;
    assign o_result.data_byte    = head.data_byte;
    assign o_result.error_code   = head.error_code;

endmodule

@@ src/ofrp_checker.sv @@
// Port-level assertions of the object file record parser, bound to the top level.
// Depends only on the top level's channel signals.
module ofrp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // nothing offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !i_out_valid)
        else $error("result offered right after reset");

    // an empty queue always takes bytes
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result queue");

    // a result first appears only after a byte is taken
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !$past(i_out_valid) && $past(i_rst_n) && $past(i_rst_n, 2))
        |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without an accepted byte");

endmodule

bind object_file_record_parser_top ofrp_checker u_ofrp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready)
);
